// ===== src/ois_pkg.sv =====
package ois_pkg;

    localparam int UNIVERSE_DEF     = 256;
    localparam int CLUSTER_SIZE_DEF = 16;
    localparam int KEY_W            = 8;
    localparam int OP_W             = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_MEMBER = 3'd2,
        OP_SUCC   = 3'd3,
        OP_PRED   = 3'd4
    } op_t;

    // bit scan request: direction, and whether the start position is ignored
    typedef struct packed {
        logic up;
        logic all;
    } scan_ctl_t;

endpackage

// ===== src/ois_ram.sv =====
module ois_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
)
(
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ois_scan.sv =====
module ois_scan
    import ois_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic [WIDTH-1:0]         vec,
    input  logic [$clog2(WIDTH)-1:0] pos,
    input  scan_ctl_t                ctl,
    output logic                     hit,
    output logic [$clog2(WIDTH)-1:0] idx
);

    localparam int PW = $clog2(WIDTH);

    // nearest set bit strictly above or below pos, or lowest / highest when all
    always_comb begin
        hit = 1'b0;
        idx = '0;
        if (ctl.up) begin
            for (int i = WIDTH - 1; i >= 0; i--) begin
                if (vec[i] && (ctl.all || (PW'(i) > pos))) begin
                    hit = 1'b1;
                    idx = PW'(i);
                end
            end
        end else begin
            for (int i = 0; i < WIDTH; i++) begin
                if (vec[i] && (ctl.all || (PW'(i) < pos))) begin
                    hit = 1'b1;
                    idx = PW'(i);
                end
            end
        end
    end

endmodule

// ===== src/ordered_integer_set.sv =====
// channel   direction  tdata        tuser
// s_        in         key [7:0]    opcode [2:0]
// m_        out        result_key   found
//
// insert, delete and member test go from transfer in through ST_WORD to ST_RESP; successor
// and predecessor may also pass through ST_SUM and ST_NEXT, set by the single cluster word
// read port and the shared bit scan, which serves the cluster word and the summary in turn.
// one request at a time: s_tready is high only while idle.
// reset clears the summary at once; a cluster whose summary bit is clear reads as empty.
// a stalled result holds in the output register until m_tready.
module ordered_integer_set
    import ois_pkg::*;
#(
    parameter int UNIVERSE     = UNIVERSE_DEF,
    parameter int CLUSTER_SIZE = CLUSTER_SIZE_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,   // key
    input  logic [OP_W-1:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [KEY_W-1:0] m_tdata,   // result_key
    output logic             m_tuser    // found
);

    localparam int NUM_CLUSTERS = UNIVERSE / CLUSTER_SIZE;
    localparam int LW = $clog2(CLUSTER_SIZE);
    localparam int CW = $clog2(NUM_CLUSTERS);
    localparam int SW = (CLUSTER_SIZE > NUM_CLUSTERS) ? CLUSTER_SIZE : NUM_CLUSTERS;
    localparam int PW = $clog2(SW);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WORD = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_NEXT = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic                    inside_reg, inside_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [LW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           nxt_reg, nxt_next;
    logic [NUM_CLUSTERS-1:0] summary_reg, summary_next;
    logic                    found_reg, found_next;
    logic [KEY_W-1:0]        rkey_reg, rkey_next;

    logic                    s_xfer;
    logic [31:0]             in_wide;
    logic [CW-1:0]           in_hi;
    logic [LW-1:0]           in_lo;
    logic                    in_inside;

    logic                    ram_we;
    logic [CLUSTER_SIZE-1:0] ram_wdata;
    logic                    ram_re;
    logic [CW-1:0]           ram_raddr;
    logic [CLUSTER_SIZE-1:0] ram_rdata;
    logic [CLUSTER_SIZE-1:0] word;
    logic [CLUSTER_SIZE-1:0] onehot;

    logic [SW-1:0]           scan_vec;
    logic [PW-1:0]           scan_pos;
    scan_ctl_t               scan_ctl;
    logic                    scan_hit;
    logic [PW-1:0]           scan_idx;

    function automatic logic [KEY_W-1:0] compose(input logic [CW-1:0] c,
                                                 input logic [LW-1:0] i);
        return KEY_W'((32'(c) << LW) | 32'(i));
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_RESP);
    assign m_tdata   = rkey_reg;
    assign m_tuser   = found_reg;

    assign in_wide   = 32'(s_tdata);
    assign in_hi     = in_wide[LW +: CW];
    assign in_lo     = in_wide[0 +: LW];
    assign in_inside = in_wide < 32'(UNIVERSE);

    assign word      = ram_rdata & {CLUSTER_SIZE{summary_reg[hi_reg]}};
    assign onehot    = CLUSTER_SIZE'(1) << lo_reg;

    assign ram_re    = s_xfer || ((state_reg == ST_SUM) && scan_hit);
    assign ram_raddr = (state_reg == ST_SUM) ? CW'(scan_idx) : in_hi;

    ois_ram #(
        .WIDTH (CLUSTER_SIZE),
        .DEPTH (NUM_CLUSTERS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (hi_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        scan_vec     = '0;
        scan_pos     = '0;
        scan_ctl.up  = (op_reg == OP_SUCC);
        scan_ctl.all = 1'b0;
        case (state_reg)
            ST_WORD: begin
                scan_vec = SW'(word);
                scan_pos = PW'(lo_reg);
            end
            ST_SUM: begin
                scan_vec     = SW'(summary_reg);
                scan_pos     = PW'(hi_reg);
                scan_ctl.all = !inside_reg;
            end
            ST_NEXT: begin
                scan_vec     = SW'(ram_rdata);
                scan_ctl.all = 1'b1;
            end
            default: begin
            end
        endcase
    end

    ois_scan #(
        .WIDTH (SW)
    ) u_scan (
        .vec (scan_vec),
        .pos (scan_pos),
        .ctl (scan_ctl),
        .hit (scan_hit),
        .idx (scan_idx)
    );

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        inside_next  = inside_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        nxt_next     = nxt_reg;
        summary_next = summary_reg;
        found_next   = found_reg;
        rkey_next    = rkey_reg;
        ram_we       = 1'b0;
        ram_wdata    = word;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    op_next     = op_t'(s_tuser);
                    inside_next = in_inside;
                    hi_next     = in_hi;
                    lo_next     = in_lo;
                    found_next  = 1'b0;
                    rkey_next   = s_tdata;
                    case (op_t'(s_tuser))
                        OP_INSERT, OP_DELETE, OP_MEMBER, OP_SUCC: begin
                            state_next = in_inside ? ST_WORD : ST_RESP;
                        end
                        OP_PRED: begin
                            state_next = in_inside ? ST_WORD : ST_SUM;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_WORD: begin
                state_next = ST_RESP;
                case (op_reg)
                    OP_INSERT: begin
                        ram_we               = 1'b1;
                        ram_wdata            = word | onehot;
                        summary_next[hi_reg] = 1'b1;
                        found_next           = 1'b1;
                    end
                    OP_DELETE: begin
                        ram_we               = 1'b1;
                        ram_wdata            = word & ~onehot;
                        summary_next[hi_reg] = |(word & ~onehot);
                        found_next           = 1'b1;
                    end
                    OP_MEMBER: begin
                        found_next = word[lo_reg];
                    end
                    OP_SUCC, OP_PRED: begin
                        if (scan_hit) begin
                            found_next = 1'b1;
                            rkey_next  = compose(hi_reg, LW'(scan_idx));
                        end else begin
                            state_next = ST_SUM;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SUM: begin
                if (scan_hit) begin
                    nxt_next   = CW'(scan_idx);
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_NEXT: begin
                found_next = 1'b1;
                rkey_next  = compose(nxt_reg, LW'(scan_idx));
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            summary_reg <= '0;
        end else begin
            state_reg   <= state_next;
            summary_reg <= summary_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        inside_reg <= inside_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        nxt_reg    <= nxt_next;
        found_reg  <= found_next;
        rkey_reg   <= rkey_next;
    end

endmodule

// ===== src/ois_checker.sv =====
module ois_checker
    import ois_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [KEY_W-1:0] m_tdata,
    input logic             m_tuser
);

    // one request in flight: never taking input while a result is shown
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after input transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("not idle after result transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("not idle after reset");

endmodule

bind ordered_integer_set ois_checker u_ois_checker (.*);

// ===== verif/set_reply_checker.sv =====
`timescale 1ns / 100ps

module set_reply_checker
    import ois_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,   // key
    input  logic [OP_W-1:0]  s_tuser,   // opcode
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [KEY_W-1:0] m_tdata,   // result_key
    input  logic             m_tuser,   // found
    output int               errors,
    output int               pending
);

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key;
    } reply_t;

    bit [UNIVERSE_DEF-1:0] key_present;
    reply_t                expected_replies[$];
    reply_t                oldest;

    initial begin
        key_present = '0;
        errors      = 0;
        pending     = 0;
    end

    // updates the key set and returns the reply the block owes for this request
    function automatic reply_t apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
        reply_t r;
        int     i;
        r.found = 1'b0;
        r.key   = k;
        case (op)
            OP_INSERT: begin
                key_present[k] = 1'b1;
                r.found = 1'b1;
            end
            OP_DELETE: begin
                key_present[k] = 1'b0;
                r.found = 1'b1;
            end
            OP_MEMBER: begin
                r.found = key_present[k];
            end
            OP_SUCC: begin
                for (i = int'(k) + 1; i < UNIVERSE_DEF; i++) begin
                    if (key_present[i] && !r.found) begin
                        r.found = 1'b1;
                        r.key   = KEY_W'(i);
                    end
                end
            end
            OP_PRED: begin
                for (i = int'(k) - 1; i >= 0; i--) begin
                    if (key_present[i] && !r.found) begin
                        r.found = 1'b1;
                        r.key   = KEY_W'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unrequested result_key", int'(m_tdata), -1);
                end else begin
                    oldest = expected_replies.pop_front();
                    if (m_tuser !== oldest.found)
                        report_mismatch("found", int'(m_tuser), int'(oldest.found));
                    if (m_tdata !== oldest.key)
                        report_mismatch("result_key", int'(m_tdata), int'(oldest.key));
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_request(s_tuser, s_tdata));
        end
        pending = expected_replies.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ois_pkg::*;

    localparam int N_RANDOM       = 1325;
    localparam int PHASE_LEN      = 225;
    localparam int QUIET_TAIL     = 150;
    localparam int LONG_HOLD_AT   = 300;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int INSERT_BIAS[6] = '{85, 50, 20, 95, 35, 60};

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [KEY_W-1:0] s_tdata  = '0;   // key
    logic [OP_W-1:0]  s_tuser  = '0;   // opcode
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [KEY_W-1:0] m_tdata;         // result_key
    logic             m_tuser;         // found

    int errors;
    int pending;
    int n_sent         = 0;
    int stall_cycles   = 0;
    bit quiet          = 1'b0;
    bit long_hold_done = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ordered_integer_set u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    set_reply_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    task automatic offer_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    // receiver: random back-pressure plus one long hold-off to fill the block
    initial begin
        int hold;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!long_hold_done && n_sent >= LONG_HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 19);
                repeat (hold) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        logic [3:0]       hot_a;
        logic [3:0]       hot_b;
        int               bias;
        int               pick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty set
        offer_request(OP_SUCC,   8'd0);
        offer_request(OP_PRED,   8'd255);
        offer_request(OP_MEMBER, 8'd0);
        offer_request(OP_DELETE, 8'd5);
        // extremes, duplicate insert
        offer_request(OP_INSERT, 8'd0);
        offer_request(OP_INSERT, 8'd255);
        offer_request(OP_INSERT, 8'd0);
        offer_request(OP_MEMBER, 8'd0);
        offer_request(OP_MEMBER, 8'd255);
        offer_request(OP_SUCC,   8'd0);
        offer_request(OP_PRED,   8'd255);
        offer_request(OP_SUCC,   8'd255);
        offer_request(OP_PRED,   8'd0);
        // same cluster and across clusters
        offer_request(OP_INSERT, 8'd17);
        offer_request(OP_INSERT, 8'd31);
        offer_request(OP_SUCC,   8'd16);
        offer_request(OP_SUCC,   8'd17);
        offer_request(OP_SUCC,   8'd31);
        offer_request(OP_PRED,   8'd255);
        offer_request(OP_DELETE, 8'd31);
        offer_request(OP_PRED,   8'd255);
        offer_request(OP_DELETE, 8'd17);
        offer_request(OP_SUCC,   8'd0);
        offer_request(OP_MEMBER, 8'd17);
        // unused opcodes
        offer_request(OP_W'(int'(OP_PRED) + 1), 8'hAA);
        offer_request(OP_W'(int'(OP_PRED) + 2), 8'h55);
        offer_request({OP_W{1'b1}}, 8'hFF);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                bias  = INSERT_BIAS[n / PHASE_LEN];
                hot_a = 4'($urandom_range(0, 15));
                hot_b = 4'($urandom_range(0, 15));
            end
            quiet = (n >= N_RANDOM - QUIET_TAIL);
            pick  = $urandom_range(0, 99);
            if (pick < 4) begin
                op = OP_W'($urandom_range(int'(OP_PRED) + 1, (1 << OP_W) - 1));
            end else if (pick < 52) begin
                op = ($urandom_range(0, 99) < bias) ? OP_INSERT : OP_DELETE;
            end else begin
                case ($urandom_range(0, 2))
                    0:       op = OP_MEMBER;
                    1:       op = OP_SUCC;
                    default: op = OP_PRED;
                endcase
            end
            case ($urandom_range(0, 3))
                0:       k = KEY_W'($urandom_range(0, 255));
                1:       k = {hot_a, 4'($urandom_range(0, 15))};
                2:       k = {hot_b, 4'($urandom_range(0, 15))};
                default: k = {4'($urandom_range(0, 15)), {4{$urandom_range(0, 1) == 1}}};
            endcase
            offer_request(op, k);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== ordered_integer_set.f =====
src/ois_pkg.sv
src/ois_ram.sv
src/ois_scan.sv
src/ordered_integer_set.sv
src/ois_checker.sv
verif/set_reply_checker.sv
verif/testbench.sv
